// File: src/bsr_pkg.sv
// ============================================================================
// bsr_pkg - byte stream reassembler package
// Action codes, field widths and default sizes shared by the reassembler.
// ============================================================================
`default_nettype none

package bsr_pkg;

    // Default window depth in bytes
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FINAL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_END   = 2'd2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [COUNT_W-1:0]  count_t;

endpackage

`default_nettype wire

// File: src/bsr_ram.sv
// ============================================================================
// bsr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/byte_stream_reassembler.sv
// ============================================================================
// byte_stream_reassembler - in-order rebuild of an offset-tagged byte stream
// Stores bytes in a window ring held in RAM, tracks valid marks in flops and
// drains contiguous bytes from the head one beat per emitted byte.
// ============================================================================
// A beat that drains nothing gives its status beat at the next edge.
// A beat that fills the head slot starts a drain that walks ST_READ (RAM read),
// then ST_EMIT (output load, held while the output stalls) for each byte.
// Drain rate is set by the read-then-emit sequencer; input stalls until it ends.
// Reset clears valid marks, head offset, pending count and end flag at once;
// the byte RAM is not cleared and needs no clearing pass.
`default_nettype none

module byte_stream_reassembler #(
    parameter int CAPACITY = bsr_pkg::CAPACITY_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // Input channel
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire bsr_pkg::action_t action,
    input  wire bsr_pkg::index_t  stream_index,
    input  wire bsr_pkg::byte_t   data_byte,
    // Output channel
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 byte_valid,
    output bsr_pkg::byte_t       out_byte,
    output bsr_pkg::index_t      out_offset,
    output logic                 stream_closed,
    output bsr_pkg::count_t      pending_count,
    output logic                 last
);

    import bsr_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int SUM_W  = SLOT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Control state
    logic [1:0]          state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    index_t              head_reg, head_next;
    logic [SLOT_W-1:0]   head_slot_reg, head_slot_next;
    count_t              count_reg, count_next;
    logic                end_reg, end_next;

    // Output register
    logic   out_valid_reg, out_valid_next;
    logic   byte_valid_reg, byte_valid_next;
    byte_t  out_byte_reg, out_byte_next;
    index_t out_offset_reg, out_offset_next;
    logic   closed_reg, closed_next;
    count_t pend_reg, pend_next;
    logic   last_reg, last_next;

    // Datapath
    logic              out_free;
    logic              accept;
    index_t            delta;
    logic              in_window;
    logic              before_head;
    logic [SUM_W-1:0]  slot_sum;
    logic [SUM_W-1:0]  slot_wrap;
    logic [SLOT_W-1:0] in_slot;
    logic              do_store;
    logic              do_end;
    logic [SLOT_W-1:0] next_slot;
    logic              ram_re;
    byte_t             ram_rdata;

    // Byte window storage
    bsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_window_ram (
        .clk   (clk),
        .we    (do_store),
        .waddr (in_slot),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (head_slot_reg),
        .rdata (ram_rdata)
    );

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    // Window position and ring slot of the incoming beat
    assign delta       = stream_index - head_reg;
    assign in_window   = (delta < INDEX_W'(CAPACITY));
    assign before_head = delta[INDEX_W-1];
    assign slot_sum    = {1'b0, head_slot_reg} + {1'b0, delta[SLOT_W-1:0]};
    assign slot_wrap   = slot_sum - SUM_W'(CAPACITY);
    assign in_slot     = (slot_sum >= SUM_W'(CAPACITY)) ? slot_wrap[SLOT_W-1:0]
                                                        : slot_sum[SLOT_W-1:0];

    // Store and end-marker decisions
    assign do_store = accept && (action inside {ACT_BYTE, ACT_FINAL}) && in_window
                      && !valid_reg[in_slot];
    assign do_end   = accept && (action inside {ACT_FINAL, ACT_END})
                      && (in_window || before_head);

    // Slot after the head
    assign next_slot = (head_slot_reg == SLOT_W'(CAPACITY - 1)) ? '0
                                                                : head_slot_reg + 1'b1;

    assign ram_re = (state_reg == ST_READ);

    // Sequencer: accept, then walk contiguous slots from the head
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        head_next       = head_reg;
        head_slot_next  = head_slot_reg;
        count_next      = count_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg && out_stall;
        byte_valid_next = byte_valid_reg;
        out_byte_next   = out_byte_reg;
        out_offset_next = out_offset_reg;
        closed_next     = closed_reg;
        pend_next       = pend_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_store)
                    begin
                        valid_next[in_slot] = 1'b1;
                        count_next          = count_reg + 1'b1;
                    end
                    if (do_end)
                    begin
                        end_next = 1'b1;
                    end
                    if (do_store && (delta == '0))
                    begin
                        // Head slot filled: start the drain
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // Nothing to drain: send one status beat
                        out_valid_next  = 1'b1;
                        byte_valid_next = 1'b0;
                        out_byte_next   = '0;
                        out_offset_next = '0;
                        closed_next     = end_next && (count_next == '0);
                        pend_next       = count_next;
                        last_next       = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    // Emit the head byte and advance
                    valid_next[head_slot_reg] = 1'b0;
                    head_next                 = head_reg + 1'b1;
                    head_slot_next            = next_slot;
                    count_next                = count_reg - 1'b1;
                    out_valid_next            = 1'b1;
                    byte_valid_next           = 1'b1;
                    out_byte_next             = ram_rdata;
                    out_offset_next           = head_reg;
                    closed_next               = end_reg && (count_next == '0);
                    pend_next                 = count_next;
                    last_next                 = !valid_next[next_slot];
                    state_next                = last_next ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            head_slot_reg <= '0;
            count_reg     <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            head_slot_reg <= head_slot_next;
            count_reg     <= count_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        byte_valid_reg <= byte_valid_next;
        out_byte_reg   <= out_byte_next;
        out_offset_reg <= out_offset_next;
        closed_reg     <= closed_next;
        pend_reg       <= pend_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign byte_valid    = byte_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_offset    = out_offset_reg;
    assign stream_closed = closed_reg;
    assign pending_count = pend_reg;
    assign last          = last_reg;

    // Pending count tracks the number of valid marks
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("pending count out of step with valid marks");

    // Draining only ever reads a valid head slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_EMIT) |-> valid_reg[head_slot_reg])
        else $error("drain on an empty head slot");

    // Head slot is empty whenever the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !valid_reg[head_slot_reg])
        else $error("idle with a filled head slot");

    // Head offset and head slot advance together
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |-> (head_slot_reg != $past(head_slot_reg)))
        else $error("head offset moved without the head slot");

endmodule

`default_nettype wire

// File: tb/tb_byte_stream_reassembler.sv
// ----------------------------------------------------------------------------
// tb_byte_stream_reassembler - self-checking bench for the stream reassembler
// Feeds offset-tagged bytes (shuffled chunks, holes filled late, duplicates,
// out-of-window and end markers) through the input channel. A local window
// model predicts every output beat, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
module tb_byte_stream_reassembler;
    timeunit 1ns;
    timeprecision 1ps;

    import bsr_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int NUM_ITEMS = 260;
    localparam int DRAIN_CYCLES = 300;
    localparam action_t ACT_UNKNOWN = 2'd3;

    typedef struct {
        action_t act;
        index_t  idx;
        byte_t   dat;
    } seg_item_t;

    typedef struct packed {
        logic   has_byte;
        byte_t  dat;
        index_t offset;
        logic   closed;
        count_t pending;
        logic   fin;
    } out_beat_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    action_t action = ACT_BYTE;
    index_t  stream_index = '0;
    byte_t   data_byte = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    logic    byte_valid;
    byte_t   out_byte;
    index_t  out_offset;
    logic    stream_closed;
    count_t  pending_count;
    logic    last;

    seg_item_t segment_q[$];
    out_beat_t assembled_q[$];
    int        stim_total = 1;
    int        beats_in = 0;
    int        errors = 0;

    // window model
    byte_t     win_bytes[CAP];
    logic      win_valid[CAP];
    index_t    head_ofs = '0;
    int        unassembled = 0;
    logic      end_flag = 1'b0;

    byte_stream_reassembler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .stream_index  (stream_index),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_valid    (byte_valid),
        .out_byte      (out_byte),
        .out_offset    (out_offset),
        .stream_closed (stream_closed),
        .pending_count (pending_count),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Store one segment beat in the window, then drain contiguous bytes from the head
    function automatic void reassemble(action_t act, index_t idx, byte_t dat);
        index_t    delta;
        logic      in_win;
        logic      behind;
        int        slot;
        int        n;
        out_beat_t b;
        delta  = idx - head_ofs;
        in_win = delta < CAP;
        behind = delta[31];
        n      = 0;
        if (act <= ACT_END && (in_win || behind))
        begin
            if (act != ACT_END && in_win)
            begin
                slot = idx % CAP;
                if (!win_valid[slot])
                begin
                    win_bytes[slot] = dat;
                    win_valid[slot] = 1'b1;
                    unassembled++;
                end
            end
            if (act != ACT_BYTE)
                end_flag = 1'b1;
        end
        while (n < CAP && win_valid[head_ofs % CAP])
        begin
            slot = head_ofs % CAP;
            win_valid[slot] = 1'b0;
            if (unassembled > 0)
                unassembled--;
            b.has_byte = 1'b1;
            b.dat      = win_bytes[slot];
            b.offset   = head_ofs;
            b.closed   = end_flag && unassembled == 0;
            b.pending  = count_t'(unassembled);
            b.fin      = 1'b0;
            assembled_q.push_back(b);
            head_ofs++;
            n++;
        end
        if (n == 0)
        begin
            b.has_byte = 1'b0;
            b.dat      = '0;
            b.offset   = '0;
            b.closed   = end_flag && unassembled == 0;
            b.pending  = count_t'(unassembled);
            b.fin      = 1'b1;
            assembled_q.push_back(b);
        end
        else
        begin
            assembled_q[$].fin = 1'b1;
        end
    endfunction

    function automatic void push_seg(action_t act, index_t idx, byte_t dat);
        seg_item_t s;
        s.act = act;
        s.idx = idx;
        s.dat = dat;
        segment_q.push_back(s);
    endfunction

    // Idle percentage for the current third of the run (0: sender, 1: receiver)
    function automatic int idle_pct(bit receiver);
        int ph;
        ph = (beats_in * 3) / stim_total;
        if (ph == 0)
            return receiver ? 46 : 22;
        else if (ph == 1)
            return receiver ? 22 : 46;
        return 0;
    endfunction

    // Driver: advance to the next segment beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin : seg_driver
        logic      take;
        seg_item_t nxt;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            action       <= ACT_BYTE;
            stream_index <= '0;
            data_byte    <= '0;
        end
        else
        begin
            take = in_valid && !in_stall;
            if (take)
            begin
                reassemble(action, stream_index, data_byte);
                beats_in++;
            end
            if (!in_valid || take)
            begin
                if (segment_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
                begin
                    nxt = segment_q.pop_front();
                    in_valid     <= 1'b1;
                    action       <= nxt.act;
                    stream_index <= nxt.idx;
                    data_byte    <= nxt.dat;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted output beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : out_monitor
        out_beat_t got;
        out_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.has_byte = byte_valid;
                got.dat      = out_byte;
                got.offset   = out_offset;
                got.closed   = stream_closed;
                got.pending  = pending_count;
                got.fin      = last;
                if (assembled_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected beat: v=%0b b=%02h ofs=%0h cl=%0b pend=%0d last=%0b",
                                 got.has_byte, got.dat, got.offset, got.closed, got.pending,
                                 got.fin);
                    errors++;
                end
                else
                begin
                    want = assembled_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch exp: v=%0b b=%02h ofs=%0h cl=%0b pend=%0d last=%0b",
                                     want.has_byte, want.dat, want.offset, want.closed,
                                     want.pending, want.fin);
                            $display("         got: v=%0b b=%02h ofs=%0h cl=%0b pend=%0d last=%0b",
                                     got.has_byte, got.dat, got.offset, got.closed,
                                     got.pending, got.fin);
                        end
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    initial
    begin : stimulus
        index_t gen_head;
        logic   held_ok;
        index_t held_idx;
        byte_t  held_dat;
        logic   had_held;
        index_t prev_idx;
        byte_t  prev_dat;
        int     order[$];
        byte_t  cdat[CAP];
        int     len;
        int     hole;
        int     held_pos;
        int     j;
        int     k;
        int     tmp;
        int     goal;
        action_t act;

        for (int i = 0; i < CAP; i++)
        begin
            win_bytes[i] = '0;
            win_valid[i] = 1'b0;
        end

        // directed: out of order, duplicate, before head, window edges, unknown code
        push_seg(ACT_BYTE, 32'd1, 8'hFF);
        push_seg(ACT_BYTE, 32'd1, 8'h00);
        push_seg(ACT_BYTE, 32'd0, 8'h00);
        push_seg(ACT_BYTE, 32'hFFFF_FFFF, 8'h5A);
        push_seg(ACT_BYTE, 32'd65, 8'hA5);
        push_seg(ACT_FINAL, 32'd66, 8'h3C);
        push_seg(ACT_END, 32'h8000_0001, 8'h00);
        push_seg(ACT_UNKNOWN, 32'd2, 8'h77);
        push_seg(ACT_FINAL, 32'd0, 8'hC3);
        // fill a run in reverse so the last beat drains all of it
        for (int i = 9; i >= 2; i--)
            push_seg(ACT_BYTE, index_t'(i), byte_t'($urandom));
        push_seg(ACT_END, 32'd10, 8'h00);

        // random: shuffled chunks with late holes, duplicates and some noise
        gen_head = 32'd10;
        held_ok  = 1'b0;
        held_idx = '0;
        held_dat = '0;
        goal     = NUM_ITEMS;
        while (segment_q.size() < goal)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                case ($urandom_range(0, 5))
                    0, 1: push_seg(action_t'($urandom_range(0, 2)), index_t'($urandom),
                                   byte_t'($urandom));
                    2: push_seg(action_t'($urandom_range(0, 2)),
                                gen_head + CAP + $urandom_range(0, 15), byte_t'($urandom));
                    3: push_seg(action_t'($urandom_range(0, 2)),
                                gen_head - 1 - $urandom_range(0, 7), byte_t'($urandom));
                    4: push_seg(ACT_UNKNOWN, gen_head + $urandom_range(0, 7),
                                byte_t'($urandom));
                    default: push_seg(ACT_END, gen_head + $urandom_range(0, CAP - 1), 8'h00);
                endcase
            end
            else
            begin
                had_held = held_ok;
                prev_idx = held_idx;
                prev_dat = held_dat;
                held_ok  = 1'b0;
                len = (!had_held && $urandom_range(0, 19) == 0) ? CAP : $urandom_range(1, 24);
                order.delete();
                for (int i = 0; i < len; i++)
                begin
                    order.push_back(i);
                    cdat[i] = byte_t'($urandom);
                end
                for (int i = len - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                // full-window chunk: hold back the head byte so it drains all at once
                if (len == CAP)
                begin
                    for (int i = 0; i < len; i++)
                        if (order[i] == 0)
                            j = i;
                    order.delete(j);
                    order.push_back(0);
                end
                hole = -1;
                if (len > 1 && len < CAP && $urandom_range(0, 3) == 0)
                    hole = $urandom_range(0, len - 1);
                held_pos = had_held ? $urandom_range(0, len - 1) : -1;
                for (int i = 0; i < len; i++)
                begin
                    if (i == held_pos)
                        push_seg(ACT_BYTE, prev_idx, prev_dat);
                    if (order[i] == hole)
                    begin
                        held_ok  = 1'b1;
                        held_idx = gen_head + hole;
                        held_dat = cdat[hole];
                        continue;
                    end
                    act = (order[i] == len - 1 && $urandom_range(0, 9) == 0)
                          ? ACT_FINAL : ACT_BYTE;
                    push_seg(act, gen_head + order[i], cdat[order[i]]);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        k = order[$urandom_range(0, i)];
                        push_seg(ACT_BYTE, gen_head + k,
                                 $urandom_range(0, 1) ? cdat[k] : byte_t'($urandom));
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    push_seg(ACT_END, gen_head + len, 8'h00);
                gen_head += len;
            end
        end
        if (held_ok)
            push_seg(ACT_BYTE, held_idx, held_dat);
        stim_total = segment_q.size();

        // hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all input beats, then for every predicted output beat
        while (segment_q.size() > 0 || in_valid)
            @(posedge clk);
        while (assembled_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && assembled_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: byte_stream_reassembler.f
src/bsr_pkg.sv
src/bsr_ram.sv
src/byte_stream_reassembler.sv
tb/tb_byte_stream_reassembler.sv
